/* design/polygon_edge_crossing_tests_defines.svh */
// ----------------------------------------------------------------------------
// Polygon edge crossing tests: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POLYGON_EDGE_CROSSING_TESTS_DEFINES_SVH
`define POLYGON_EDGE_CROSSING_TESTS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define PEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be true at a clock edge out of reset
`define PEC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PEC_ASSERT(lbl, prop, msg)
`define PEC_NEVER(lbl, cond, msg)
`endif

`endif

/* design/pec_pkg.sv */
// ----------------------------------------------------------------------------
// pec_pkg
// Shared constants, codes and types of the polygon edge crossing tests.
// ----------------------------------------------------------------------------
package pec_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int AW           = $clog2(MAX_VERTICES);      // vertex address
  localparam int NW           = $clog2(MAX_VERTICES + 1);  // vertex count
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CNT_W        = 7;                         // crossings field
  localparam int PADDR_W      = 4;
  localparam int CROSS_LAT    = 3;                         // cross unit stages

  localparam logic signed [COORD_BITS-1:0] FAR_RESET = COORD_BITS'(10000);

  // opcodes
  localparam logic [2:0] OP_WRITE_A = 3'd0;
  localparam logic [2:0] OP_WRITE_B = 3'd1;
  localparam logic [2:0] OP_OVERLAP = 3'd2;
  localparam logic [2:0] OP_INSIDE_A = 3'd3;
  localparam logic [2:0] OP_INSIDE_B = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_OVERLAP  = 2'd0;
  localparam logic [1:0] KIND_INSIDE_A = 2'd1;
  localparam logic [1:0] KIND_INSIDE_B = 2'd2;

  // register indexes
  localparam logic [1:0] REG_COUNT_A   = 2'd0;
  localparam logic [1:0] REG_COUNT_B   = 2'd1;
  localparam logic [1:0] REG_RAY_FAR_X = 2'd2;
  localparam logic [1:0] REG_RAY_FAR_Y = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // segment p0-p1 against segment p2-p3
  typedef struct packed {
    logic    valid;
    vertex_t p0;
    vertex_t p1;
    vertex_t p2;
    vertex_t p3;
  } pair_t;

endpackage

/* design/pec_vertex_ram.sv */
// ----------------------------------------------------------------------------
// pec_vertex_ram
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pec_vertex_ram import pec_pkg::*; (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  vertex_t       wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output vertex_t       rdata_o
);

  vertex_t mem [MAX_VERTICES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* design/pec_cross_unit.sv */
// ----------------------------------------------------------------------------
// pec_cross_unit
// Pipelined strict segment crossing test: differences, products, compare.
// ----------------------------------------------------------------------------
module pec_cross_unit import pec_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  pair_t pair_i,
  output logic  hit_valid_o,
  output logic  hit_o
);

  function automatic diff_t sub(coord_t a, coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic prod_t mul(diff_t a, diff_t b);
    return PROD_W'(a) * PROD_W'(b);
  endfunction

  // d: relative to p0 (d1 = p1, d2 = p2, d3 = p3); e: relative to p1
  logic  s1_v_q, s2_v_q;
  diff_t d1x_q, d1y_q, d2x_q, d2y_q, d3x_q, d3y_q, e2x_q, e2y_q, e3x_q, e3y_q;
  prod_t lhs_q [4];
  prod_t rhs_q [4];
  logic  t0, t1, t2, t3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      hit_valid_o <= 1'b0;
    end else begin
      s1_v_q      <= pair_i.valid;
      s2_v_q      <= s1_v_q;
      hit_valid_o <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1x_q <= sub(pair_i.p1.x, pair_i.p0.x);
    d1y_q <= sub(pair_i.p1.y, pair_i.p0.y);
    d2x_q <= sub(pair_i.p2.x, pair_i.p0.x);
    d2y_q <= sub(pair_i.p2.y, pair_i.p0.y);
    d3x_q <= sub(pair_i.p3.x, pair_i.p0.x);
    d3y_q <= sub(pair_i.p3.y, pair_i.p0.y);
    e2x_q <= sub(pair_i.p2.x, pair_i.p1.x);
    e2y_q <= sub(pair_i.p2.y, pair_i.p1.y);
    e3x_q <= sub(pair_i.p3.x, pair_i.p1.x);
    e3y_q <= sub(pair_i.p3.y, pair_i.p1.y);
  end

  // turn(a,b,c): (cy-ay)*(bx-ax) > (by-ay)*(cx-ax)
  always_ff @(posedge clk_i) begin
    lhs_q[0] <= mul(d3y_q, d2x_q);  rhs_q[0] <= mul(d2y_q, d3x_q);  // p0,p2,p3
    lhs_q[1] <= mul(e3y_q, e2x_q);  rhs_q[1] <= mul(e2y_q, e3x_q);  // p1,p2,p3
    lhs_q[2] <= mul(d2y_q, d1x_q);  rhs_q[2] <= mul(d1y_q, d2x_q);  // p0,p1,p2
    lhs_q[3] <= mul(d3y_q, d1x_q);  rhs_q[3] <= mul(d1y_q, d3x_q);  // p0,p1,p3
  end

  assign t0 = lhs_q[0] > rhs_q[0];
  assign t1 = lhs_q[1] > rhs_q[1];
  assign t2 = lhs_q[2] > rhs_q[2];
  assign t3 = lhs_q[3] > rhs_q[3];

  always_ff @(posedge clk_i) begin
    hit_o <= (t0 != t1) && (t2 != t3);
  end

endmodule

/* design/polygon_edge_crossing_tests.sv */
// ----------------------------------------------------------------------------
// polygon_edge_crossing_tests
// Vertex stores for two closed polygons, edge overlap and point inside tests.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. Vertex writes
// (opcodes 0 and 1) never raise busy; opcodes 5 to 7 are dropped. A query
// raises busy until its result appears; the result stands on the result
// ports for exactly one cycle with result_valid_o high and cannot be held
// off, so capture it in that cycle. A new command may be issued in the
// result cycle. Timing is set by the single read port of each vertex store,
// at most one edge pair per cycle: an inside test of a polygon with n
// vertices takes n + 1 reads, and an edge overlap query with na, nb vertices
// takes na * (nb + 1) + 1 reads (A edge held in registers, B streamed once
// per A edge). The read and crossing pipeline then drains; a query with an
// empty polygon skips the reads and only drains. Counts above the store
// depth are taken as full. The vertex stores have no reset; every vertex in
// use must be written before a query reads it. Configuration (APB, 4
// registers at 4-byte stride) must only be written while the block is idle.
// ----------------------------------------------------------------------------
`include "polygon_edge_crossing_tests_defines.svh"

module polygon_edge_crossing_tests import pec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // command
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            opcode_i,
  input  logic [5:0]            vertex_index_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  // result
  output logic                  result_valid_o,
  output logic [1:0]            query_kind_o,
  output logic                  answer_o,
  output logic [CNT_W-1:0]      crossings_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREF   = 2'd1;  // fetch A[0] for overlap
  localparam logic [1:0] ST_STREAM = 2'd2;
  localparam logic [1:0] ST_DRAIN  = 2'd3;

  localparam int DRAIN_CYCLES = CROSS_LAT + 1;   // RAM read + cross pipeline
  localparam int DRW          = $clog2(DRAIN_CYCLES);

  // ---------------------------------------------------------------- config
  logic [6:0] count_a_q, count_b_q;
  coord_t     far_x_q, far_y_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
      far_x_q   <= FAR_RESET;
      far_y_q   <= FAR_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_COUNT_A:   count_a_q <= pwdata[6:0];
        REG_COUNT_B:   count_b_q <= pwdata[6:0];
        REG_RAY_FAR_X: far_x_q   <= $signed(pwdata[COORD_BITS-1:0]);
        REG_RAY_FAR_Y: far_y_q   <= $signed(pwdata[COORD_BITS-1:0]);
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COUNT_A:   prdata = 32'(count_a_q);
      REG_COUNT_B:   prdata = 32'(count_b_q);
      REG_RAY_FAR_X: prdata = 32'(far_x_q);
      REG_RAY_FAR_Y: prdata = 32'(far_y_q);
    endcase
  end

  // counts clipped to the store depth
  logic [NW-1:0] n_a, n_b;
  assign n_a = (32'(count_a_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_a_q);
  assign n_b = (32'(count_b_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_b_q);

  // ---------------------------------------------------------------- command
  logic    accept, idx_ok, we_a, we_b;
  vertex_t wvertex;

  assign accept  = start && !busy;
  assign idx_ok  = 32'(vertex_index_i) < MAX_VERTICES;
  assign we_a    = accept && (opcode_i == OP_WRITE_A) && idx_ok;
  assign we_b    = accept && (opcode_i == OP_WRITE_B) && idx_ok;
  assign wvertex = '{x: coord_x_i, y: coord_y_i};

  // ---------------------------------------------------------------- sequencer
  logic [1:0]     state_q;
  logic [1:0]     mode_q;
  logic [NW-1:0]  k_q, n_q, na_q;
  logic [AW-1:0]  i_q;
  logic [DRW-1:0] drain_q;
  vertex_t        qpt_q;
  logic           res_valid_q;

  logic           overlap, k_last, row_last;
  logic [NW-1:0]  i_inc;
  logic [AW-1:0]  i2, stream_addr, raddr_a;
  logic           re;

  assign overlap     = mode_q == KIND_OVERLAP;
  assign k_last      = k_q == n_q;
  assign i_inc       = NW'(i_q) + NW'(1);
  assign row_last    = i_inc == na_q;
  assign i2          = row_last ? '0 : i_inc[AW-1:0];
  assign stream_addr = k_last ? '0 : k_q[AW-1:0];
  assign raddr_a     = overlap ? ((state_q == ST_PREF) ? '0 : i2) : stream_addr;
  assign re          = (state_q == ST_PREF) || (state_q == ST_STREAM);
  assign busy        = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= KIND_OVERLAP;
      k_q         <= '0;
      n_q         <= '0;
      na_q        <= '0;
      i_q         <= '0;
      drain_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          k_q     <= '0;
          i_q     <= '0;
          drain_q <= '0;
          if (accept) begin
            priority case (opcode_i)
              OP_OVERLAP: begin
                mode_q  <= KIND_OVERLAP;
                na_q    <= n_a;
                n_q     <= n_b;
                state_q <= (n_a == '0 || n_b == '0) ? ST_DRAIN : ST_PREF;
              end
              OP_INSIDE_A: begin
                mode_q  <= KIND_INSIDE_A;
                n_q     <= n_a;
                state_q <= (n_a == '0) ? ST_DRAIN : ST_STREAM;
              end
              OP_INSIDE_B: begin
                mode_q  <= KIND_INSIDE_B;
                n_q     <= n_b;
                state_q <= (n_b == '0) ? ST_DRAIN : ST_STREAM;
              end
              default: ;  // writes and unused opcodes stay idle
            endcase
          end
        end
        ST_PREF: state_q <= ST_STREAM;
        ST_STREAM: begin
          if (k_last) begin
            k_q <= '0;
            if (overlap && !row_last) begin
              i_q <= i_inc[AW-1:0];
            end else begin
              state_q <= ST_DRAIN;
            end
          end else begin
            k_q <= k_q + NW'(1);
          end
        end
        ST_DRAIN: begin
          if (drain_q == DRW'(DRAIN_CYCLES - 1)) begin
            state_q     <= ST_IDLE;
            res_valid_q <= 1'b1;
          end else begin
            drain_q <= drain_q + DRW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      qpt_q <= wvertex;
    end
  end

  // ---------------------------------------------------------------- stores
  vertex_t rdata_a, rdata_b;

  pec_vertex_ram u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (AW'(vertex_index_i)),
    .wdata_i (wvertex),
    .re_i    (re),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  pec_vertex_ram u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (AW'(vertex_index_i)),
    .wdata_i (wvertex),
    .re_i    (re),
    .raddr_i (stream_addr),
    .rdata_o (rdata_b)
  );

  // ---------------------------------------------------------------- edge build
  // tags are registered with the read address, so they line up with the read data
  logic    dv_q, dfirst_q, dpref_q;
  vertex_t a_p_q, a_n_q, prev_q, rsel;
  vertex_t far_pt;
  pair_t   pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q     <= 1'b0;
      dfirst_q <= 1'b0;
      dpref_q  <= 1'b0;
    end else begin
      dv_q     <= state_q == ST_STREAM;
      dfirst_q <= k_q == '0;
      dpref_q  <= state_q == ST_PREF;
    end
  end

  assign rsel   = (mode_q == KIND_INSIDE_A) ? rdata_a : rdata_b;
  assign far_pt = '{x: far_x_q, y: far_y_q};

  // a_p/a_n: current A edge; prev_q: previous streamed vertex
  always_ff @(posedge clk_i) begin
    if (dpref_q) begin
      a_n_q <= rdata_a;
    end else if (dv_q) begin
      prev_q <= rsel;
      if (dfirst_q) begin
        a_p_q <= a_n_q;
        a_n_q <= rdata_a;
      end
    end
  end

  always_comb begin
    pair.valid = dv_q && !dfirst_q;
    if (overlap) begin
      pair.p0 = a_p_q;
      pair.p1 = a_n_q;
      pair.p2 = prev_q;
      pair.p3 = rsel;
    end else begin
      pair.p0 = prev_q;
      pair.p1 = rsel;
      pair.p2 = far_pt;
      pair.p3 = qpt_q;
    end
  end

  logic hit_valid, hit;

  pec_cross_unit u_cross (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pair),
    .hit_valid_o (hit_valid),
    .hit_o       (hit)
  );

  // ---------------------------------------------------------------- result
  // overlap ORs the hits, inside tests keep parity and a saturating count
  logic             acc_bit_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_bit_q <= 1'b0;
      cnt_q     <= '0;
    end else if (accept) begin
      acc_bit_q <= 1'b0;
      cnt_q     <= '0;
    end else if (hit_valid && hit) begin
      if (overlap) begin
        acc_bit_q <= 1'b1;
      end else begin
        acc_bit_q <= ~acc_bit_q;
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign query_kind_o   = mode_q;
  assign answer_o       = acc_bit_q;
  assign crossings_o    = cnt_q;

  // ---------------------------------------------------------------- checks
  `PEC_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o, "result strobe held")
  `PEC_ASSERT(a_strobe_idle, result_valid_o |-> !busy, "result shown while busy")
  `PEC_ASSERT(a_hit_in_query, hit_valid |-> busy, "crossing result outside a query")
  `PEC_ASSERT(a_pair_in_stream, pair.valid |-> (state_q == ST_STREAM || state_q == ST_DRAIN), "edge pair outside stream")
  `PEC_NEVER(a_overlap_zero, result_valid_o && (query_kind_o == KIND_OVERLAP) && (crossings_o != '0), "overlap with count")

endmodule
